// ----- sv/ibac_pkg.sv -----
// ---------------------------------------------------------------------------
// ibac_pkg
// shared constants, types and helpers of the interval booking admission core
// ---------------------------------------------------------------------------
package ibac_pkg;

  localparam int TimeBits  = 10;
  localparam int CountBits = 8;
  localparam int LimitBits = 8;
  localparam int NodeBits  = TimeBits + 1;
  localparam int DepthBits = $clog2(TimeBits);

  localparam logic [TimeBits:0]  SlotEnd    = (TimeBits + 1)'(1) << TimeBits;
  localparam logic [LimitBits-1:0] LimitReset = LimitBits'(2);

  typedef logic [TimeBits-1:0]  slot_t;
  typedef logic [NodeBits-1:0]  node_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [DepthBits:0]   level_t;

  // subtree max including own add, and add owed to the subtree
  typedef struct packed {
    count_t t;
    count_t d;
  } node_word_t;

  typedef struct packed {
    logic       en;
    logic       we;
    node_t      addr;
    node_word_t wdata;
  } ram_req_t;

  // tree node at a given level on the path from the root to slot x
  function automatic node_t node_at(slot_t x, level_t lvl);
    logic [NodeBits-1:0] leaf;
    leaf = {1'b1, x};
    return leaf >> (TimeBits - int'(lvl));
  endfunction

endpackage

// ----- sv/ibac_if.sv -----
// ---------------------------------------------------------------------------
// ibac_if
// request and response channels of the interval booking admission core
// ---------------------------------------------------------------------------
interface ibac_req_if;
  logic                       valid;
  logic                       ready;
  logic [ibac_pkg::TimeBits-1:0] start_time;
  logic [ibac_pkg::TimeBits:0]   end_time;

  modport source (output valid, output start_time, output end_time, input ready);
  modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

interface ibac_rsp_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, output accepted, input ready);
  modport sink   (input valid, input accepted, output ready);
endinterface

// ----- sv/ibac_node_ram.sv -----
// ---------------------------------------------------------------------------
// ibac_node_ram
// single-port node store, one read or write per cycle, registered read data
// ---------------------------------------------------------------------------
module ibac_node_ram (
  input  logic                 clk_i,
  input  ibac_pkg::ram_req_t   req_i,
  output ibac_pkg::node_word_t rdata_o
);

  ibac_pkg::node_word_t mem [2**ibac_pkg::NodeBits];
  ibac_pkg::node_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/interval_booking_admission_core.sv -----
// ---------------------------------------------------------------------------
// interval_booking_admission_core
// admits bookings of [start, end) while no slot reaches the overlap limit
// ---------------------------------------------------------------------------
// After reset the node store is cleared, one entry a cycle, all 2048 entries
// (2 * 2^TimeBits); no request is taken during that pass. A request is then
// walked through a segment tree held in one single-port memory: the query goes
// down one level at a time visiting at most two path nodes and their children
// (states QP, QC0, QC1, QEV for each node), and an accepted booking goes back
// up the same paths with read-modify-write of each node and its children
// (states UP, UC0, UC1, UW0, UW1, UWP). An empty interval skips both walks, a
// rejected one the update walk. The memory port allows one access a cycle.
module interval_booking_admission_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ibac_pkg::LimitBits-1:0]      cfg_wdata_i,
  ibac_req_if.sink                            req_i,
  ibac_rsp_if.source                          rsp_o
);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_QP    = 13'b0000000000100,
    S_QC0   = 13'b0000000001000,
    S_QC1   = 13'b0000000010000,
    S_QEV   = 13'b0000000100000,
    S_UP    = 13'b0000001000000,
    S_UC0   = 13'b0000010000000,
    S_UC1   = 13'b0000100000000,
    S_UW0   = 13'b0001000000000,
    S_UW1   = 13'b0010000000000,
    S_UWP   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic [ibac_pkg::DepthBits-1:0] depth_q, depth_d;
  logic side_q, side_d;
  ibac_pkg::count_t accl_q, accl_d, accr_q, accr_d, peak_q, peak_d;
  ibac_pkg::count_t dp_q;
  ibac_pkg::node_word_t pw_q, c0_q, c1_q;
  ibac_pkg::slot_t lo_q, hi_q;
  ibac_pkg::node_t clr_q, clr_d;
  logic res_q, res_d;
  logic out_valid_q, out_valid_d, out_acc_q, out_acc_d;
  logic [ibac_pkg::LimitBits-1:0] limit_q;

  ibac_pkg::ram_req_t   ram_req;
  ibac_pkg::node_word_t rd;

  ibac_pkg::level_t lvl, lvl_nx;
  ibac_pkg::node_t pl, pr, p, c0, c1, pcl, pcr;
  logic same, leaf_lvl, cov0, cov1, reject, req_fire, empty;
  ibac_pkg::count_t acc_s, cand, acc_new, t0n, t1n, tmax;
  logic [ibac_pkg::TimeBits:0] end_c;

  ibac_node_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rd)
  );

  assign lvl      = {1'b0, depth_q};
  assign lvl_nx   = lvl + ibac_pkg::level_t'(1);
  assign pl       = ibac_pkg::node_at(lo_q, lvl);
  assign pr       = ibac_pkg::node_at(hi_q, lvl);
  assign same     = (pl == pr);
  assign p        = side_q ? pr : pl;
  assign c0       = ibac_pkg::node_t'({p, 1'b0});
  assign c1       = ibac_pkg::node_t'({p, 1'b1});
  assign pcl      = ibac_pkg::node_at(lo_q, lvl_nx);
  assign pcr      = ibac_pkg::node_at(hi_q, lvl_nx);
  assign leaf_lvl = (depth_q == ibac_pkg::DepthBits'(ibac_pkg::TimeBits - 1));
  assign cov0     = leaf_lvl ? (c0 >= pcl && c0 <= pcr) : (c0 > pcl && c0 < pcr);
  assign cov1     = leaf_lvl ? (c1 >= pcl && c1 <= pcr) : (c1 > pcl && c1 < pcr);
  assign acc_s    = side_q ? accr_q : accl_q;
  assign cand     = ibac_pkg::count_t'(rd.t + acc_s + dp_q);
  assign acc_new  = ibac_pkg::count_t'(acc_s + dp_q);
  assign t0n      = cov0 ? ibac_pkg::count_t'(c0_q.t + 1'b1) : c0_q.t;
  assign t1n      = cov1 ? ibac_pkg::count_t'(c1_q.t + 1'b1) : c1_q.t;
  assign tmax     = (t0n > t1n) ? t0n : t1n;

  assign req_fire = req_i.valid && req_i.ready;
  assign end_c    = (req_i.end_time > ibac_pkg::SlotEnd) ? ibac_pkg::SlotEnd
                                                         : req_i.end_time;
  assign empty    = ({1'b0, req_i.start_time} >= end_c);

  always_comb begin
    peak_d = peak_q;
    if ((state_q == S_QC1 && cov0) || (state_q == S_QEV && cov1)) begin
      if (cand > peak_q) begin
        peak_d = cand;
      end
    end
  end

  assign reject = (32'(peak_d) >= 32'(limit_q)) || (peak_d == '1);

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.accepted = out_acc_q;

  always_comb begin
    ram_req       = '0;
    ram_req.addr  = p;
    ram_req.wdata = '0;
    case (state_q)
      S_CLEAR: begin
        ram_req.en   = 1'b1;
        ram_req.we   = 1'b1;
        ram_req.addr = clr_q;
      end
      S_QP, S_UP: begin
        ram_req.en = 1'b1;
      end
      S_QC0, S_UC0: begin
        ram_req.en   = 1'b1;
        ram_req.addr = c0;
      end
      S_QC1, S_UC1: begin
        ram_req.en   = 1'b1;
        ram_req.addr = c1;
      end
      S_UW0: begin
        ram_req.en      = 1'b1;
        ram_req.we      = 1'b1;
        ram_req.addr    = c0;
        ram_req.wdata.t = t0n;
        ram_req.wdata.d = cov0 ? ibac_pkg::count_t'(c0_q.d + 1'b1) : c0_q.d;
      end
      S_UW1: begin
        ram_req.en      = 1'b1;
        ram_req.we      = 1'b1;
        ram_req.addr    = c1;
        ram_req.wdata.t = t1n;
        ram_req.wdata.d = cov1 ? ibac_pkg::count_t'(c1_q.d + 1'b1) : c1_q.d;
      end
      S_UWP: begin
        ram_req.en      = 1'b1;
        ram_req.we      = 1'b1;
        ram_req.wdata.t = ibac_pkg::count_t'(tmax + pw_q.d);
        ram_req.wdata.d = pw_q.d;
      end
      default: begin
        ram_req.en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    side_d      = side_q;
    accl_d      = accl_q;
    accr_d      = accr_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + ibac_pkg::node_t'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          depth_d = '0;
          side_d  = 1'b0;
          accl_d  = '0;
          accr_d  = '0;
          if (empty) begin
            res_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_QP;
          end
        end
      end
      S_QP:  state_d = S_QC0;
      S_QC0: state_d = S_QC1;
      S_QC1: state_d = S_QEV;
      S_QEV: begin
        if (side_q) begin
          accr_d = acc_new;
        end else begin
          accl_d = acc_new;
          if (same) begin
            accr_d = acc_new;
          end
        end
        if (!side_q && !same) begin
          side_d  = 1'b1;
          state_d = S_QP;
        end else begin
          side_d = 1'b0;
          if (leaf_lvl) begin
            if (reject) begin
              res_d   = 1'b0;
              state_d = S_DONE;
            end else begin
              state_d = S_UP;
            end
          end else begin
            depth_d = depth_q + 1'b1;
            state_d = S_QP;
          end
        end
      end
      S_UP:  state_d = S_UC0;
      S_UC0: state_d = S_UC1;
      S_UC1: state_d = S_UW0;
      S_UW0: state_d = S_UW1;
      S_UW1: state_d = S_UWP;
      S_UWP: begin
        if (!side_q && !same) begin
          side_d  = 1'b1;
          state_d = S_UP;
        end else begin
          side_d = 1'b0;
          if (depth_q == '0) begin
            res_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            depth_d = depth_q - 1'b1;
            state_d = S_UP;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_acc_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      depth_q     <= '0;
      side_q      <= 1'b0;
      accl_q      <= '0;
      accr_q      <= '0;
      peak_q      <= '0;
      clr_q       <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
      limit_q     <= ibac_pkg::LimitReset;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      side_q      <= side_d;
      accl_q      <= accl_d;
      accr_q      <= accr_d;
      peak_q      <= (state_q == S_IDLE) ? '0 : peak_d;
      clr_q       <= clr_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_acc_q   <= out_acc_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      lo_q <= req_i.start_time;
      hi_q <= ibac_pkg::slot_t'(end_c - 1'b1);
    end
    if (state_q == S_QC0) begin
      dp_q <= rd.d;
    end
    if (state_q == S_UC0) begin
      pw_q <= rd;
    end
    if (state_q == S_UC1) begin
      c0_q <= rd;
    end
    if (state_q == S_UW0) begin
      c1_q <= rd;
    end
  end

  // right path is visited only where it has split from the left one
  a_side_split : assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q |-> !same) else $error("right path visited while paths merged");

  // the store is written only by the clearing pass and the update walk
  a_write_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.en && ram_req.we) |-> (state_q == S_CLEAR || state_q == S_UW0 ||
                                    state_q == S_UW1 || state_q == S_UWP))
    else $error("unexpected node write");

  // an update only starts when the interval max is below the limit and the count maximum
  a_update_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QEV && state_d == S_UP) |->
      (32'(peak_d) < 32'(limit_q) && peak_d != '1))
    else $error("update started on a full interval");

  // a finished result is held until the output register is free
  a_done_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !rsp_o.ready) |=> state_q == S_DONE)
    else $error("result overwrote a pending transfer");

endmodule

// ----- test/ibac_checker.sv -----
// ---------------------------------------------------------------------------
// ibac_checker
// watches request and response transfers, predicts admission, compares
// ---------------------------------------------------------------------------
module ibac_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ibac_pkg::LimitBits-1:0] cfg_wdata_i,
  input  logic                           req_valid_i,
  input  logic                           req_ready_i,
  input  logic [ibac_pkg::TimeBits-1:0]  req_start_i,
  input  logic [ibac_pkg::TimeBits:0]    req_end_i,
  input  logic                           rsp_valid_i,
  input  logic                           rsp_ready_i,
  input  logic                           rsp_accepted_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             admitted_o,
  output int                             refused_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 1 << ibac_pkg::TimeBits;
  localparam int CountMax = (1 << ibac_pkg::CountBits) - 1;

  int slot_count [Slots];
  int limit;
  bit admit_q [$];

  function automatic bit predict_admission(int lo, int hi);
    int peak;
    peak = 0;
    if (hi > Slots) hi = Slots;
    if (lo >= hi) return 1'b1;
    for (int s = lo; s < hi; s++) if (slot_count[s] > peak) peak = slot_count[s];
    if (peak >= limit || peak >= CountMax) return 1'b0;
    for (int s = lo; s < hi; s++) slot_count[s]++;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      foreach (slot_count[s]) slot_count[s] = 0;
      limit = ibac_pkg::LimitReset;
      admit_q.delete();
      errors_o = 0;
      pending_o = 0;
      admitted_o = 0;
      refused_o = 0;
    end else begin
      if (cfg_we_i) limit = cfg_wdata_i;
      if (req_valid_i && req_ready_i)
        admit_q.push_back(predict_admission(req_start_i, req_end_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (admit_q.size() == 0) begin
          $display("%0t: response with none expected, actual %0d", $time, rsp_accepted_i);
          errors_o++;
        end else begin
          want = admit_q.pop_front();
          if (want) admitted_o++; else refused_o++;
          if (rsp_accepted_i !== want) begin
            $display("%0t: accepted mismatch expected %0d actual %0d", $time, want,
                     rsp_accepted_i);
            errors_o++;
          end
        end
      end
      pending_o = admit_q.size();
    end
  end
endmodule

// ----- test/interval_booking_admission_core_tb.sv -----
// ---------------------------------------------------------------------------
// interval_booking_admission_core_tb
// drives booking requests and limit changes through the admission core
// ---------------------------------------------------------------------------
module interval_booking_admission_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [ibac_pkg::LimitBits-1:0] cfg_wdata_i;
  int                             errors, pending, admitted, refused;
  int                             src_idle, snk_idle;
  longint                         cycles;
  int                             sent;

  ibac_req_if req_if ();
  ibac_rsp_if rsp_if ();

  interval_booking_admission_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  ibac_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_start_i   (req_if.start_time),
    .req_end_i     (req_if.end_time),
    .rsp_valid_i   (rsp_if.valid),
    .rsp_ready_i   (rsp_if.ready),
    .rsp_accepted_i(rsp_if.accepted),
    .errors_o      (errors),
    .pending_o     (pending),
    .admitted_o    (admitted),
    .refused_o     (refused)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 2_000_000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic book(int lo, int hi);
    while ($urandom_range(99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.start_time <= lo[ibac_pkg::TimeBits-1:0];
    req_if.end_time   <= hi[ibac_pkg::TimeBits:0];
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  task automatic set_limit(int v);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[ibac_pkg::LimitBits-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_book();
    int lo, len, r;
    r = $urandom_range(99);
    if (r < 70) begin
      lo  = $urandom_range(1023);
      len = ($urandom_range(3) == 0) ? $urandom_range(1024) : $urandom_range(24);
      book(lo, lo + len > 2047 ? 2047 : lo + len);
    end else if (r < 90) begin
      book($urandom_range(1023), $urandom_range(2047));
    end else begin
      lo = $urandom_range(1023);
      book(lo, $urandom_range(lo));
    end
  endtask

  initial begin
    int limits [5] = '{1, 3, 255, 0, 2};
    src_idle = 8;
    snk_idle = 69;
    sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.start_time = '0;
    req_if.end_time = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, empty, clipped, fill to limit
    book(0, 1024);
    book(0, 2047);
    book(0, 1);
    book(1023, 1024);
    book(1023, 2047);
    book(5, 5);
    book(9, 3);
    book(1023, 0);
    book(10, 20);
    book(15, 25);
    book(12, 13);
    book(682, 1365);
    book(341, 342);
    set_limit(255);
    for (int i = 0; i < 6; i++) book(100, 108);
    set_limit(1);
    book(100, 101);
    book(200, 201);
    set_limit(0);
    book(300, 301);
    book(7, 7);
    set_limit(2);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 8 : (ph == 1) ? 69 : 0;
      snk_idle = (ph == 0) ? 69 : (ph == 1) ? 8 : 0;
      for (int k = 0; k < 5; k++) begin
        set_limit(limits[(k + ph) % 5]);
        for (int i = 0; i < 82; i++) random_book();
      end
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    $display("%0d bookings sent: %0d admitted, %0d refused, limits 0 to 255, three stall mixes",
             sent, admitted, refused);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
